>>> rtl/r5sp_pkg.sv
// raid-5 stripe parity engine: shared constants, codes and transaction types
// no dependencies; imported by raid5_stripe_parity_engine_unit
`timescale 1ns / 1ps

package r5sp_pkg;

    // array and datapath sizes
    localparam int MAX_DRIVES     = 16;
    localparam int ROW_BITS       = 16;
    localparam int WORD_BITS      = 32;
    localparam int DRIVE_BITS     = 4;
    localparam int COUNT_BITS     = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;
    localparam int MIN_DRIVES     = 3;
    localparam logic [COUNT_BITS-1:0] DRIVE_COUNT_RESET = COUNT_BITS'(4);

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_COUNT = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOST_DRIVE  = CFG_INDEX_BITS'(1);

    // input operation
    typedef enum logic {
        OP_ENCODE  = 1'b0,
        OP_RECOVER = 1'b1
    } op_t;

    // kind of emitted block
    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_PAD       = 2'd1,
        KIND_PARITY    = 2'd2,
        KIND_RECOVERED = 2'd3
    } kind_t;

    // emitter state: which result of the held item goes out next
    typedef enum logic [2:0] {
        JOB_IDLE,
        JOB_DATA,
        JOB_PAD,
        JOB_PARITY,
        JOB_RECOVER
    } job_state_t;

    typedef struct packed {
        op_t                   opcode;
        logic [WORD_BITS-1:0]  word;
        logic [DRIVE_BITS-1:0] source_drive;
        logic                  final_req;
    } in_item_t;

    typedef struct packed {
        logic [DRIVE_BITS-1:0] target_drive;
        logic [ROW_BITS-1:0]   stripe_row;
        logic [WORD_BITS-1:0]  block;
        kind_t                 kind;
        logic                  run_end;
    } out_item_t;

endpackage

>>> rtl/raid5_stripe_parity_engine_unit.sv
// raid-5 rotating parity engine: encode layout with parity, and single-drive rebuild
// depends on r5sp_pkg
`timescale 1ns / 1ps

// Usage
//   s_ channel: one transaction per data word (encode) or surviving block
//   (recover). m_ channel: emitted blocks, run_end marks the last block an
//   input caused. cfg_ channel: index 0 drive_count, index 1 lost_drive;
//   write only while idle. Writing drive_count restarts the encode layout.
//   An encode word yields its data block, then on a final word the zero pads
//   of the unused slots, then parity when the row is full or the word is final.
//   A recover block yields one rebuilt block when marked final, nothing otherwise.
//   An accepted item's first result passes the held-item register, then the
//   output register. Throughput: one item per cycle while each item causes
//   at most one result and the output is not stalled; an item causing more
//   results holds the input until its last result is loaded, as the emitter
//   drives one result per cycle into the output register while it is free.
//   Reset (aresetn low, synchronous): drive_count 4, lost_drive 0, row and
//   slot counters and accumulators cleared, output valid low.
//   Stall: when m_ready is low the output register holds its transaction
//   and s_ready drops once the pending item has a result waiting to leave.
module raid5_stripe_parity_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  r5sp_pkg::in_item_t                  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output r5sp_pkg::out_item_t                 m_payload,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [r5sp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [r5sp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import r5sp_pkg::*;

    // configuration and architectural state
    logic [COUNT_BITS-1:0] drive_count_reg, drive_count_next;
    logic [DRIVE_BITS-1:0] lost_drive_reg, lost_drive_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [DRIVE_BITS-1:0] slot_reg, slot_next;
    logic [DRIVE_BITS-1:0] pd_reg, pd_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic [WORD_BITS-1:0]  racc_reg, racc_next;
    logic [ROW_BITS-1:0]   rrow_reg, rrow_next;

    // held item for the emitter
    job_state_t            job_state_reg, job_state_next;
    logic [WORD_BITS-1:0]  job_word_reg;
    logic [WORD_BITS-1:0]  job_acc_reg;
    logic [DRIVE_BITS-1:0] job_drive_reg;
    logic [ROW_BITS-1:0]   job_row_reg;
    logic [DRIVE_BITS-1:0] job_pd_reg;
    logic [DRIVE_BITS-1:0] job_slot_reg, job_slot_next;
    logic [DRIVE_BITS-1:0] job_end_reg;
    logic                  job_pad_reg;
    logic                  job_par_reg;

    // output register
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_payload_reg, m_payload_next;

    logic                  s_accept;
    logic                  cfg_accept;
    logic                  emit_load;
    logic                  res_last;
    out_item_t             res;

    logic [COUNT_BITS-1:0] n_active;
    logic [DRIVE_BITS-1:0] data_slots;
    logic [DRIVE_BITS-1:0] slot_cur;
    logic [DRIVE_BITS-1:0] slot_inc;
    logic [DRIVE_BITS-1:0] data_drive;
    logic [DRIVE_BITS-1:0] pd_inc;
    logic [DRIVE_BITS-1:0] pad_drive;
    logic [WORD_BITS-1:0]  acc_upd;
    logic [WORD_BITS-1:0]  racc_upd;
    logic                  enc_pad;
    logic                  enc_par;
    logic                  rec_hit;

    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign m_valid    = m_valid_reg;
    assign m_payload  = m_payload_reg;

    // clamp drive count into the supported range
    always_comb begin
        if (drive_count_reg < COUNT_BITS'(MIN_DRIVES)) begin
            n_active = COUNT_BITS'(MIN_DRIVES);
        end else if (drive_count_reg > COUNT_BITS'(MAX_DRIVES)) begin
            n_active = COUNT_BITS'(MAX_DRIVES);
        end else begin
            n_active = drive_count_reg;
        end
        data_slots = DRIVE_BITS'(n_active - COUNT_BITS'(1));
    end

    // encode placement: skip the parity drive, detect row fill
    always_comb begin
        slot_cur   = (slot_reg >= data_slots) ? '0 : slot_reg;
        data_drive = (slot_cur < pd_reg) ? slot_cur : DRIVE_BITS'(slot_cur + 1'b1);
        slot_inc   = DRIVE_BITS'(slot_cur + 1'b1);
        acc_upd    = acc_reg ^ s_payload.word;
        enc_pad    = s_payload.final_req && (slot_inc < data_slots);
        enc_par    = s_payload.final_req || (slot_inc >= data_slots);
        if (COUNT_BITS'({1'b0, pd_reg}) + COUNT_BITS'(1) == n_active) begin
            pd_inc = '0;
        end else begin
            pd_inc = DRIVE_BITS'(pd_reg + 1'b1);
        end
    end

    // recover: fold in blocks from drives of the array other than the lost one
    always_comb begin
        rec_hit  = (COUNT_BITS'({1'b0, s_payload.source_drive}) < n_active)
                   && (s_payload.source_drive != lost_drive_reg);
        racc_upd = rec_hit ? (racc_reg ^ s_payload.word) : racc_reg;
    end

    // architectural state update on input and configuration transactions
    always_comb begin
        drive_count_next = drive_count_reg;
        lost_drive_next  = lost_drive_reg;
        row_next         = row_reg;
        slot_next        = slot_reg;
        pd_next          = pd_reg;
        acc_next         = acc_reg;
        racc_next        = racc_reg;
        rrow_next        = rrow_reg;
        if (s_accept) begin
            if (s_payload.opcode == OP_ENCODE) begin
                if (enc_par) begin
                    slot_next = '0;
                    acc_next  = '0;
                    row_next  = s_payload.final_req ? '0 : ROW_BITS'(row_reg + 1'b1);
                    // row counter wrapping to zero restarts the rotation at drive 0
                    pd_next   = (s_payload.final_req || (row_reg == '1)) ? '0 : pd_inc;
                end else begin
                    slot_next = slot_inc;
                    acc_next  = acc_upd;
                end
            end else begin
                if (s_payload.final_req) begin
                    racc_next = '0;
                    rrow_next = ROW_BITS'(rrow_reg + 1'b1);
                end else begin
                    racc_next = racc_upd;
                end
            end
        end
        if (cfg_accept) begin
            if (cfg_index == CFG_DRIVE_COUNT) begin
                drive_count_next = cfg_data[COUNT_BITS-1:0];
                row_next         = '0;
                slot_next        = '0;
                pd_next          = '0;
                acc_next         = '0;
            end else if (cfg_index == CFG_LOST_DRIVE) begin
                lost_drive_next = cfg_data[DRIVE_BITS-1:0];
            end
        end
    end

    // emitter next state
    always_comb begin
        job_state_next = job_state_reg;
        job_slot_next  = job_slot_reg;
        if (s_accept) begin
            job_slot_next = slot_inc;
            if (s_payload.opcode == OP_ENCODE) begin
                job_state_next = JOB_DATA;
            end else if (s_payload.final_req) begin
                job_state_next = JOB_RECOVER;
            end else begin
                job_state_next = JOB_IDLE;
            end
        end else if (emit_load) begin
            unique case (job_state_reg)
                JOB_DATA: begin
                    if (job_pad_reg) begin
                        job_state_next = JOB_PAD;
                    end else if (job_par_reg) begin
                        job_state_next = JOB_PARITY;
                    end else begin
                        job_state_next = JOB_IDLE;
                    end
                end
                JOB_PAD: begin
                    job_slot_next = DRIVE_BITS'(job_slot_reg + 1'b1);
                    if (DRIVE_BITS'(job_slot_reg + 1'b1) >= job_end_reg) begin
                        job_state_next = JOB_PARITY;
                    end
                end
                JOB_PARITY:  job_state_next = JOB_IDLE;
                JOB_RECOVER: job_state_next = JOB_IDLE;
                default:     job_state_next = JOB_IDLE;
            endcase
        end
    end

    // emitter outputs: the result presented to the output register
    always_comb begin
        pad_drive = (job_slot_reg < job_pd_reg) ? job_slot_reg
                                                : DRIVE_BITS'(job_slot_reg + 1'b1);
        res            = '0;
        res.stripe_row = job_row_reg;
        res_last       = 1'b0;
        unique case (job_state_reg)
            JOB_IDLE: begin
                res_last = 1'b0;
            end
            JOB_DATA: begin
                res.target_drive = job_drive_reg;
                res.block        = job_word_reg;
                res.kind         = KIND_DATA;
                res_last         = !job_pad_reg && !job_par_reg;
            end
            JOB_PAD: begin
                res.target_drive = pad_drive;
                res.block        = '0;
                res.kind         = KIND_PAD;
                res_last         = 1'b0;
            end
            JOB_PARITY: begin
                res.target_drive = job_pd_reg;
                res.block        = job_acc_reg;
                res.kind         = KIND_PARITY;
                res_last         = 1'b1;
            end
            JOB_RECOVER: begin
                res.target_drive = job_drive_reg;
                res.block        = job_word_reg;
                res.kind         = KIND_RECOVERED;
                res_last         = 1'b1;
            end
            default: begin
                res_last = 1'b0;
            end
        endcase
        res.run_end = res_last;
    end

    // handshake: the held item moves into the output register when it is free
    assign emit_load = (job_state_reg != JOB_IDLE) && (!m_valid_reg || m_ready);
    assign s_ready   = (job_state_reg == JOB_IDLE) || (emit_load && res_last);

    // output register next value
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;
        if (emit_load) begin
            m_valid_next   = 1'b1;
            m_payload_next = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_count_reg <= DRIVE_COUNT_RESET;
            lost_drive_reg  <= '0;
            row_reg         <= '0;
            slot_reg        <= '0;
            pd_reg          <= '0;
            acc_reg         <= '0;
            racc_reg        <= '0;
            rrow_reg        <= '0;
            job_state_reg   <= JOB_IDLE;
            m_valid_reg     <= 1'b0;
        end else begin
            drive_count_reg <= drive_count_next;
            lost_drive_reg  <= lost_drive_next;
            row_reg         <= row_next;
            slot_reg        <= slot_next;
            pd_reg          <= pd_next;
            acc_reg         <= acc_next;
            racc_reg        <= racc_next;
            rrow_reg        <= rrow_next;
            job_state_reg   <= job_state_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers of the held item and the output
    always_ff @(posedge aclk) begin
        job_slot_reg  <= job_slot_next;
        m_payload_reg <= m_payload_next;
        if (s_accept) begin
            job_acc_reg <= acc_upd;
            job_pd_reg  <= pd_reg;
            job_end_reg <= data_slots;
            job_pad_reg <= enc_pad;
            job_par_reg <= enc_par;
            if (s_payload.opcode == OP_ENCODE) begin
                job_word_reg  <= s_payload.word;
                job_drive_reg <= data_drive;
                job_row_reg   <= row_reg;
            end else begin
                job_word_reg  <= racc_upd;
                job_drive_reg <= lost_drive_reg;
                job_row_reg   <= rrow_reg;
            end
        end
    end

`ifndef SYNTHESIS
    // parity drive always lies inside the active array
    a_pd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        COUNT_BITS'({1'b0, pd_reg}) < n_active)
        else $error("parity drive outside the array");

    // slot counter never reaches the data slot count
    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg < data_slots)
        else $error("slot counter past the row");

    // an output stall with a pending result blocks new input transactions
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && job_state_reg != JOB_IDLE) |-> !s_ready)
        else $error("input taken while a result is stuck");

    // an encode transaction always starts with its data block
    a_encode_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_payload.opcode == OP_ENCODE) |=> job_state_reg == JOB_DATA)
        else $error("encode transaction did not start with data");
`endif

endmodule
